>>> rtl/pjd_pkg.sv
// shared types and constants for the priority job dispatcher
// used by pjd_ctrl, pjd_datapath and priority_job_dispatcher
package pjd_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] time_stamp;
    logic [31:0] process_number;
    logic [15:0] job_tag;
    logic [6:0]  importance;
    logic [31:0] duration;
    logic [4:0]  wanted;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_time_stamp;
    logic [31:0] out_process;
    logic [15:0] out_tag;
    logic [6:0]  out_importance;
    logic [31:0] out_duration;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] stamp;
    logic [31:0] process;
    logic [15:0] tag;
    logic [6:0]  imp;
    logic [31:0] dur;
    logic [31:0] order;
  } slot_rec_t;

  localparam logic KIND_JOB    = 1'b0;
  localparam logic KIND_ASSIGN = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_JOB  = 7'b0000010,
    ST_CNT  = 7'b0000100,
    ST_LIM  = 7'b0001000,
    ST_SCAN = 7'b0010000,
    ST_DISP = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic latch;
    logic store;
    logic cnt_run;
    logic lim_load;
    logic scan_init;
    logic scan_run;
    logic dispatch;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic cnt_done;
    logic lim_zero;
    logic scan_done;
    logic out_taken;
    logic all_sent;
  } status_t;

  // smaller key is served first
  function automatic logic [102:0] prio_key(slot_rec_t r);
    return {~r.imp, r.stamp, r.dur, r.order};
  endfunction

endpackage

>>> rtl/pjd_ctrl.sv
// sequencing state machine of the dispatcher
// depends on pjd_pkg for state, command and status types
module pjd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pjd_pkg::status_t sts,
  output pjd_pkg::cmd_t    cmd
);
  import pjd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = (sts.in_kind == KIND_ASSIGN) ? ST_CNT : ST_JOB;
        end
      end
      ST_JOB: begin
        cmd.store = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CNT: begin
        cmd.cnt_run = 1'b1;
        if (sts.cnt_done) state_nxt = ST_LIM;
      end
      ST_LIM: begin
        cmd.lim_load = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = sts.lim_zero ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        cmd.dispatch = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_taken) begin
          if (sts.all_sent) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/pjd_datapath.sv
// job table, free-slot stack, processor free times and output register
// depends on pjd_pkg; driven by pjd_ctrl commands
module pjd_datapath #(
  parameter int QUEUE_DEPTH       = 256,
  parameter int MAX_PROCESSORS    = 16,
  parameter int IMPORTANCE_LEVELS = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pjd_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output pjd_pkg::out_item_t out_data,
  input  pjd_pkg::cmd_t      cmd,
  output pjd_pkg::status_t   sts
);
  import pjd_pkg::*;

  localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PW   = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
  localparam int NW   = $clog2(MAX_PROCESSORS + 1);
  localparam int SCAN_MAX = (QUEUE_DEPTH > MAX_PROCESSORS) ? QUEUE_DEPTH : MAX_PROCESSORS;
  localparam int SCW  = $clog2(SCAN_MAX + 1);

  // latched request
  logic        kind_r;
  logic [31:0] t_r;
  slot_rec_t   rec_r;
  logic [4:0]  wanted_r;

  logic [4:0]  cpu_r;
  logic [31:0] free_r [MAX_PROCESSORS];
  logic [31:0] arrival_r;

  slot_rec_t   mem [QUEUE_DEPTH];
  slot_rec_t   q_r;
  logic [IDXW-1:0] stk [QUEUE_DEPTH];
  logic [IDXW-1:0] sq_r;
  logic [IDXW:0]   sp_r, hwm_r;

  logic [SCW-1:0]  s_r;
  logic [NW-1:0]   fc_r;
  logic [4:0]      limit_r, sent_r;
  logic            rdv_r, found_r;
  logic [IDXW-1:0] rdi_r, bidx_r;
  slot_rec_t       best_r;
  logic [PW-1:0]   pidx_r;
  logic [31:0]     pmin_r;
  out_item_t       out_r;
  logic            out_valid_r;

  logic [NW-1:0]   n_w;
  logic [IDXW:0]   pend_w;
  logic [31:0]     pv_w;
  logic            s_in_n;
  logic [32:0]     fin_w;
  logic [8:0]      imp_w;
  logic [31:0]     lim_w;

  assign n_w    = (32'(cpu_r) > MAX_PROCESSORS) ? NW'(MAX_PROCESSORS) : NW'(cpu_r);
  assign pend_w = hwm_r - sp_r;
  assign pv_w   = free_r[s_r[PW-1:0]];
  assign s_in_n = 32'(s_r) < 32'(n_w);
  assign fin_w  = {1'b0, t_r} + {1'b0, best_r.dur};

  always_comb begin
    imp_w = {2'b00, in_data.importance};
    if (imp_w == 9'd0) imp_w = 9'd1;
    if (32'(imp_w) > IMPORTANCE_LEVELS) imp_w = 9'(IMPORTANCE_LEVELS);
    lim_w = 32'(wanted_r);
    if (32'(fc_r) < lim_w) lim_w = 32'(fc_r);
    if (32'(pend_w) < lim_w) lim_w = 32'(pend_w);
  end

  assign sts.in_kind   = in_data.kind;
  assign sts.cnt_done  = 32'(s_r) == MAX_PROCESSORS - 1;
  assign sts.lim_zero  = (lim_w == 32'd0) || (kind_r != KIND_ASSIGN);
  assign sts.scan_done = 32'(s_r) == SCAN_MAX;
  assign sts.out_taken = out_valid_r && out_ready;
  assign sts.all_sent  = sent_r == limit_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table and stack storage
  always_ff @(posedge clk) begin
    q_r  <= mem[s_r[IDXW-1:0]];
    sq_r <= stk[IDXW'(sp_r - 1'b1)];
    if (cmd.store && pend_w < (IDXW+1)'(QUEUE_DEPTH)) begin
      mem[(sp_r != '0) ? sq_r : hwm_r[IDXW-1:0]] <= rec_r;
    end else if (cmd.dispatch) begin
      mem[bidx_r] <= {1'b0, best_r[$bits(slot_rec_t)-2:0]};
    end
    if (cmd.dispatch) stk[sp_r[IDXW-1:0]] <= bidx_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r       <= in_data.kind;
      t_r          <= in_data.time_stamp;
      wanted_r     <= in_data.wanted;
      rec_r.busy    <= 1'b1;
      rec_r.stamp   <= in_data.time_stamp;
      rec_r.process <= in_data.process_number;
      rec_r.tag     <= in_data.job_tag;
      rec_r.imp     <= imp_w[6:0];
      rec_r.dur     <= in_data.duration;
      rec_r.order   <= arrival_r;
    end
    if (cmd.lim_load) limit_r <= lim_w[4:0];
    if (cmd.scan_init) begin
      pidx_r <= '0;
      pmin_r <= free_r[0];
    end else if (cmd.scan_run && s_r != '0 && s_in_n && pv_w < pmin_r) begin
      pidx_r <= s_r[PW-1:0];
      pmin_r <= pv_w;
    end
    if (cmd.scan_run) begin
      rdi_r <= s_r[IDXW-1:0];
      if (rdv_r && q_r.busy && (!found_r || prio_key(q_r) < prio_key(best_r))) begin
        best_r <= q_r;
        bidx_r <= rdi_r;
      end
    end
    if (cmd.dispatch) begin
      out_r.out_time_stamp <= best_r.stamp;
      out_r.out_process    <= best_r.process;
      out_r.out_tag        <= best_r.tag;
      out_r.out_importance <= best_r.imp;
      out_r.out_duration   <= best_r.dur;
      out_r.last           <= (sent_r + 5'd1) == limit_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r       <= 5'd1;
      arrival_r   <= '0;
      sp_r        <= '0;
      hwm_r       <= '0;
      s_r         <= '0;
      fc_r        <= '0;
      sent_r      <= '0;
      rdv_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PROCESSORS; i++) free_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        cpu_r <= cfg_data;
        for (int i = 0; i < MAX_PROCESSORS; i++) free_r[i] <= '0;
      end
      if (cmd.latch) begin
        s_r  <= '0;
        fc_r <= '0;
      end
      if (cmd.store && pend_w < (IDXW+1)'(QUEUE_DEPTH)) begin
        arrival_r <= arrival_r + 32'd1;
        if (sp_r != '0) sp_r <= sp_r - 1'b1;
        else hwm_r <= hwm_r + 1'b1;
      end
      if (cmd.cnt_run) begin
        s_r <= s_r + 1'b1;
        if (s_in_n && pv_w <= t_r) fc_r <= fc_r + 1'b1;
      end
      if (cmd.lim_load) sent_r <= '0;
      if (cmd.scan_init) begin
        s_r     <= '0;
        rdv_r   <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.scan_run) begin
        s_r   <= s_r + 1'b1;
        rdv_r <= (32'(s_r) < QUEUE_DEPTH) && ((IDXW+1)'(s_r) < hwm_r);
        if (rdv_r && q_r.busy) found_r <= 1'b1;
      end
      if (cmd.dispatch) begin
        free_r[pidx_r] <= fin_w[32] ? 32'hFFFF_FFFF : fin_w[31:0];
        sp_r        <= sp_r + 1'b1;
        sent_r      <= sent_r + 5'd1;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/priority_job_dispatcher.sv
// top level of the priority job dispatcher
// instantiates pjd_ctrl and pjd_datapath; depends on pjd_pkg
//
// in_* channel takes one item at a time: a job (kind 0) or an assign request
// (kind 1). A job is latched, then stored in the pending table, or dropped
// when the table is full. An assign at time T first counts free processors,
// then per dispatched job sweeps the table memory one entry a cycle (its
// single read port sets the figure), with the processor minimum found in the
// same sweep. Results leave on out_* with last set on the final one; no
// result for an assign that dispatches nothing.
// The block takes a new item only after every result of the current one has
// been taken; a stalled receiver holds out_valid and the block waits.
// cfg_we/cfg_data write cpu_count and zero all processor free times; write
// only while idle. Reset (rst_n low, synchronous) empties the table, sets
// cpu_count to 1 and all free times to zero; no clearing pass is needed.
module priority_job_dispatcher #(
  parameter int QUEUE_DEPTH       = 256,
  parameter int MAX_PROCESSORS    = 16,
  parameter int IMPORTANCE_LEVELS = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pjd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pjd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data
);
  import pjd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  pjd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pjd_datapath #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PROCESSORS    (MAX_PROCESSORS),
    .IMPORTANCE_LEVELS (IMPORTANCE_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // no new item while a result is still pending
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  // the last result frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready)
    else $error("block not idle after last result");

  // a dispatch that is not last is followed by another one
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> !in_ready && !out_valid)
    else $error("dispatch sequence ended without last");

endmodule
